### rtl/toof_pkg.sv
// Shared types and constants for the topmost object occluder filter.
// No dependencies; used by every module of the block.
package toof_pkg;

   localparam int MAX_OBJECTS = 32;
   localparam int CNT_W       = $clog2(MAX_OBJECTS + 1);
   localparam int POS_W       = 32;
   localparam int IDX_W       = 6;
   localparam int RADIUS_W    = 20;
   localparam int LIM_W       = RADIUS_W + 1;
   localparam int LIM_SQ_W    = 2 * LIM_W;
   localparam int SQ_W        = 2 * POS_W;

   // (2 * 4000)^2, the overlap limit for the reset radius
   localparam logic [LIM_SQ_W-1:0] LIM_SQ_RESET = LIM_SQ_W'(64'd64000000);

   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
      logic [IDX_W-1:0]        idx;
   } entry_type;

   // queue control broadcast to every cell
   typedef struct packed {
      logic             pop;
      logic             push;
      logic [CNT_W-1:0] cnt;
   } qctl_type;

   // result of one overlap test
   typedef struct packed {
      logic valid;
      logic overlap;
      logic higher;
   } verdict_type;

endpackage

### rtl/toof_cell.sv
// One slot of the kept-object queue: holds one entry, shifts toward the head.
// Depends on toof_pkg.
module toof_cell (
   input  logic                        clock,
   input  toof_pkg::qctl_type          ctl,
   input  logic [toof_pkg::CNT_W-1:0]  slot,
   input  toof_pkg::entry_type         upper,
   input  toof_pkg::entry_type         push_entry,
   output toof_pkg::entry_type         entry
);

   toof_pkg::entry_type entry_ff;
   toof_pkg::entry_type entry_in;
   logic                hit;

   // tail slot is cnt-1 when the queue also pops this cycle
   assign hit = ctl.push && (ctl.pop ? (ctl.cnt == (slot + toof_pkg::CNT_W'(1)))
                                     : (ctl.cnt == slot));

   always_comb begin
      if (hit) begin
         entry_in = push_entry;
      end else if (ctl.pop) begin
         entry_in = upper;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

### rtl/toof_cmp.sv
// Three-stage overlap test of one queue entry against the newcomer.
// Depends on toof_pkg.
module toof_cmp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  toof_pkg::entry_type               in_entry,
   input  logic signed [toof_pkg::POS_W-1:0] new_x,
   input  logic signed [toof_pkg::POS_W-1:0] new_y,
   input  logic signed [toof_pkg::POS_W-1:0] new_z,
   input  logic [toof_pkg::LIM_SQ_W-1:0]     lim_sq,
   output logic                              busy,
   output toof_pkg::entry_type               out_entry,
   output toof_pkg::verdict_type             verdict
);

   localparam int PW = toof_pkg::POS_W;
   localparam int SW = toof_pkg::SQ_W;

   // stage 1: absolute differences, height compare
   logic signed [PW:0]  diff_x;
   logic signed [PW:0]  diff_y;
   logic [PW:0]         mag_x;
   logic [PW:0]         mag_y;
   logic                s1_valid_ff;
   logic                s1_valid_in;
   toof_pkg::entry_type s1_entry_ff;
   logic [PW-1:0]       s1_dx_ff;
   logic [PW-1:0]       s1_dy_ff;
   logic                s1_higher_ff;

   // stage 2: squares
   logic                s2_valid_ff;
   logic                s2_valid_in;
   toof_pkg::entry_type s2_entry_ff;
   logic [SW-1:0]       s2_sx_ff;
   logic [SW-1:0]       s2_sy_ff;
   logic                s2_higher_ff;

   // stage 3: sum and compare
   logic [SW:0]         sum;

   assign diff_x = {new_x[PW-1], new_x} - {in_entry.x[PW-1], in_entry.x};
   assign diff_y = {new_y[PW-1], new_y} - {in_entry.y[PW-1], in_entry.y};
   assign mag_x  = diff_x[PW] ? -diff_x : diff_x;
   assign mag_y  = diff_y[PW] ? -diff_y : diff_y;

   assign s1_valid_in = in_valid;
   assign s2_valid_in = s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_entry_ff  <= in_entry;
      s1_dx_ff     <= mag_x[PW-1:0];
      s1_dy_ff     <= mag_y[PW-1:0];
      s1_higher_ff <= (new_z > in_entry.z);
      s2_entry_ff  <= s1_entry_ff;
      s2_sx_ff     <= SW'(s1_dx_ff) * SW'(s1_dx_ff);
      s2_sy_ff     <= SW'(s1_dy_ff) * SW'(s1_dy_ff);
      s2_higher_ff <= s1_higher_ff;
   end

   assign sum = {1'b0, s2_sx_ff} + {1'b0, s2_sy_ff};

   // a carry out of 64 bits is farther than any limit
   assign verdict.valid   = s2_valid_ff;
   assign verdict.overlap = !sum[SW] && (sum[SW-1:0] < SW'(lim_sq));
   assign verdict.higher  = s2_higher_ff;
   assign out_entry       = s2_entry_ff;
   assign busy            = s1_valid_ff || s2_valid_ff;

endmodule

### rtl/topmost_object_occluder_filter_top.sv
// Topmost object occluder filter: top level with control, queue and result register.
// Depends on toof_pkg, toof_cell and toof_cmp.

// The block keeps the unoccluded objects of a set in a queue built from a row of
// MAX_OBJECTS cells. Each accepted item walks every kept entry through a three-stage
// overlap unit (difference, square, sum and compare), one entry per cycle: the entry
// leaves the queue head and, unless it is lower than the newcomer and overlapping, goes
// back in at the tail, so the list keeps its order. The first overlapping entry at least
// as high blocks the newcomer; later entries pass untouched. After the walk the newcomer
// is appended, or dropped with the overflow flag set when the queue is full. req_ready is
// high only between items. On an item with last_object set, the kept arrival numbers then
// leave the queue head one per cycle while the receiver keeps rsp_ready high, through the
// rsp register, which the next item may overlap.
// Radius writes go straight into the squared limit (2 * radius)^2, in the next cycle.
module topmost_object_occluder_filter_top (
   input  logic                                clock,
   input  logic                                reset,
   // item input
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [toof_pkg::POS_W-1:0]   req_pos_x,
   input  logic signed [toof_pkg::POS_W-1:0]   req_pos_y,
   input  logic signed [toof_pkg::POS_W-1:0]   req_pos_z,
   input  logic                                req_last_object,
   // result output
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [toof_pkg::IDX_W-1:0]          rsp_object_index,
   output logic                                rsp_overflow,
   output logic                                rsp_last_result,
   // configuration
   input  logic                                csr_wr_en,
   input  logic [toof_pkg::RADIUS_W-1:0]       csr_wr_data
);

   localparam int MAX   = toof_pkg::MAX_OBJECTS;
   localparam int CNT_W = toof_pkg::CNT_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]                     state_ff, state_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic [CNT_W-1:0]               scan_left_ff, scan_left_in;
   logic [toof_pkg::IDX_W-1:0]     arrival_ff, arrival_in;
   logic                           overflow_ff, overflow_in;
   logic                           blocked_ff, blocked_in;
   logic [toof_pkg::LIM_SQ_W-1:0]  lim_sq_ff, lim_sq_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   // newcomer, held for the whole walk
   toof_pkg::entry_type            new_ff;
   logic                           last_ff;

   logic [toof_pkg::IDX_W-1:0]     rsp_index_ff;
   logic                           rsp_overflow_ff;
   logic                           rsp_last_ff;

   logic [toof_pkg::LIM_W-1:0]     lim;
   logic                           accept;
   logic                           feed;
   logic                           scan_done;
   logic                           survive;
   logic                           append;
   logic                           emit_pop;
   logic                           set_done;
   logic                           cmp_busy;
   toof_pkg::entry_type            cmp_entry;
   toof_pkg::verdict_type          verdict;
   toof_pkg::qctl_type             qctl;
   toof_pkg::entry_type            push_entry;
   toof_pkg::entry_type            chain [0:MAX];

   // ---------------- control ----------------
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   assign feed      = (state_ff == ST_SCAN) && (scan_left_ff != '0);
   assign scan_done = (state_ff == ST_SCAN) && (scan_left_ff == '0) && !cmp_busy;

   // lower overlapping entries are dropped until the first blocker is seen
   assign survive   = verdict.valid &&
                      !(verdict.overlap && verdict.higher && !blocked_ff);
   assign append    = scan_done && !blocked_ff && (cnt_ff != CNT_W'(MAX));

   assign emit_pop  = (state_ff == ST_EMIT) && (cnt_ff != '0) &&
                      (!rsp_valid_ff || rsp_ready);
   assign set_done  = (state_ff == ST_EMIT) &&
                      ((cnt_ff == '0) || (emit_pop && (cnt_ff == CNT_W'(1))));

   assign qctl.pop   = feed || emit_pop;
   assign qctl.push  = survive || append;
   assign qctl.cnt   = cnt_ff;
   assign push_entry = append ? new_ff : cmp_entry;

   assign cnt_in = cnt_ff - CNT_W'(qctl.pop) + CNT_W'(qctl.push);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = last_ff ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (set_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      scan_left_in = scan_left_ff;
      if (accept) begin
         scan_left_in = cnt_ff;
      end else if (feed) begin
         scan_left_in = scan_left_ff - CNT_W'(1);
      end
   end

   always_comb begin
      blocked_in = blocked_ff;
      if (accept) begin
         blocked_in = 1'b0;
      end else if (verdict.valid && verdict.overlap && !verdict.higher) begin
         blocked_in = 1'b1;
      end
   end

   always_comb begin
      arrival_in = arrival_ff;
      if (set_done) begin
         arrival_in = '0;
      end else if (accept) begin
         arrival_in = arrival_ff + toof_pkg::IDX_W'(1);
      end
   end

   always_comb begin
      overflow_in = overflow_ff;
      if (set_done) begin
         overflow_in = 1'b0;
      end else if (scan_done && !blocked_ff && (cnt_ff == CNT_W'(MAX))) begin
         overflow_in = 1'b1;
      end
   end

   assign lim       = {csr_wr_data, 1'b0};
   assign lim_sq_in = csr_wr_en ? (toof_pkg::LIM_SQ_W'(lim) * toof_pkg::LIM_SQ_W'(lim))
                                : lim_sq_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         scan_left_ff <= '0;
         arrival_ff   <= '0;
         overflow_ff  <= 1'b0;
         blocked_ff   <= 1'b0;
         lim_sq_ff    <= toof_pkg::LIM_SQ_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         scan_left_ff <= scan_left_in;
         arrival_ff   <= arrival_in;
         overflow_ff  <= overflow_in;
         blocked_ff   <= blocked_in;
         lim_sq_ff    <= lim_sq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         new_ff.x   <= req_pos_x;
         new_ff.y   <= req_pos_y;
         new_ff.z   <= req_pos_z;
         new_ff.idx <= arrival_ff;
         last_ff    <= req_last_object;
      end
      if (emit_pop) begin
         rsp_index_ff    <= chain[0].idx;
         rsp_overflow_ff <= overflow_ff;
         rsp_last_ff     <= (cnt_ff == CNT_W'(1));
      end
   end

   // ---------------- queue of cells ----------------
   assign chain[MAX] = '0;

   for (genvar i = 0; i < MAX; i++) begin : g_cell
      toof_cell u_cell (
         .clock      (clock),
         .ctl        (qctl),
         .slot       (CNT_W'(i)),
         .upper      (chain[i+1]),
         .push_entry (push_entry),
         .entry      (chain[i])
      );
   end

   // ---------------- overlap unit ----------------
   toof_cmp u_cmp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (feed),
      .in_entry  (chain[0]),
      .new_x     (new_ff.x),
      .new_y     (new_ff.y),
      .new_z     (new_ff.z),
      .lim_sq    (lim_sq_ff),
      .busy      (cmp_busy),
      .out_entry (cmp_entry),
      .verdict   (verdict)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_object_index = rsp_index_ff;
   assign rsp_overflow     = rsp_overflow_ff;
   assign rsp_last_result  = rsp_last_ff;

   // ---------------- assertions ----------------
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX))
      else $error("queue count beyond capacity");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!qctl.pop && !qctl.push && !cmp_busy))
      else $error("queue moves while idle");

   a_emit_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (!cmp_busy && !verdict.valid))
      else $error("overlap unit busy during emission");

endmodule

### test/toof_occlusion_checker.sv
// Result checker for the topmost object occluder filter: watches the item, result and
// radius ports, keeps its own kept-object table and compares every result item.
// Depends on toof_pkg.
`timescale 1ns / 1ps

module toof_occlusion_checker
   import toof_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic signed [POS_W-1:0]    req_pos_x,
   input  logic signed [POS_W-1:0]    req_pos_y,
   input  logic signed [POS_W-1:0]    req_pos_z,
   input  logic                       req_last_object,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [IDX_W-1:0]           rsp_object_index,
   input  logic                       rsp_overflow,
   input  logic                       rsp_last_result,
   input  logic                       csr_wr_en,
   input  logic [RADIUS_W-1:0]        csr_wr_data,
   output int                         error_count,
   output int                         pending_count
);

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 20'd4000;
   localparam int                  SHOWN_ERRORS = 10;

   typedef struct packed {
      logic [IDX_W-1:0] obj_index;
      logic             ovf;
      logic             closes_set;
   } report_type;

   entry_type           kept_table [MAX_OBJECTS];
   int                  kept_count;
   logic [IDX_W-1:0]    arrival_num;
   logic                dropped_any;
   logic [RADIUS_W-1:0] radius;
   report_type          expected_reports [$];
   report_type          oldest;

   // queues one expected result item at the tail
   function automatic void add_expected(input report_type r);
      expected_reports = {expected_reports, r};
   endfunction

   // true when the xy distance is below 2 * radius; a squared sum past 64 bits is far
   function automatic logic xy_overlap(input entry_type e,
                                       input logic signed [POS_W-1:0] px,
                                       input logic signed [POS_W-1:0] py);
      logic signed [POS_W:0] ddx, ddy;
      logic [POS_W:0]        mx, my;
      logic [SQ_W-1:0]       sqx, sqy, limsq;
      logic [SQ_W:0]         sum;
      logic [LIM_W-1:0]      lim;
      ddx   = {px[POS_W-1], px} - {e.x[POS_W-1], e.x};
      ddy   = {py[POS_W-1], py} - {e.y[POS_W-1], e.y};
      mx    = ddx[POS_W] ? -ddx : ddx;
      my    = ddy[POS_W] ? -ddy : ddy;
      sqx   = SQ_W'(mx[POS_W-1:0]) * SQ_W'(mx[POS_W-1:0]);
      sqy   = SQ_W'(my[POS_W-1:0]) * SQ_W'(my[POS_W-1:0]);
      sum   = {1'b0, sqx} + {1'b0, sqy};
      lim   = {radius, 1'b0};
      limsq = SQ_W'(lim) * SQ_W'(lim);
      if (sum[SQ_W])
         return 1'b0;
      return sum[SQ_W-1:0] < limsq;
   endfunction

   task automatic filter_object(input logic signed [POS_W-1:0] px,
                                input logic signed [POS_W-1:0] py,
                                input logic signed [POS_W-1:0] pz,
                                input logic                    last_obj);
      logic       doomed [MAX_OBJECTS];
      logic       blocked;
      int         w;
      report_type rpt;
      blocked = 1'b0;
      for (int k = 0; k < MAX_OBJECTS; k++)
         doomed[k] = 1'b0;
      // scan in list order, stop at the first overlapping entry that is not lower
      for (int k = 0; k < kept_count && !blocked; k++) begin
         if (xy_overlap(kept_table[k], px, py)) begin
            if (pz > $signed(kept_table[k].z))
               doomed[k] = 1'b1;
            else
               blocked = 1'b1;
         end
      end
      w = 0;
      for (int k = 0; k < kept_count; k++) begin
         if (!doomed[k]) begin
            kept_table[w] = kept_table[k];
            w++;
         end
      end
      kept_count = w;
      if (!blocked) begin
         if (kept_count < MAX_OBJECTS) begin
            kept_table[kept_count].x   = px;
            kept_table[kept_count].y   = py;
            kept_table[kept_count].z   = pz;
            kept_table[kept_count].idx = arrival_num;
            kept_count++;
         end else begin
            dropped_any = 1'b1;
         end
      end
      arrival_num = arrival_num + 1'b1;
      if (last_obj) begin
         for (int k = 0; k < kept_count; k++) begin
            rpt.obj_index  = kept_table[k].idx;
            rpt.ovf        = dropped_any;
            rpt.closes_set = (k == kept_count - 1);
            add_expected(rpt);
         end
         kept_count  = 0;
         arrival_num = '0;
         dropped_any = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         kept_count  = 0;
         arrival_num = '0;
         dropped_any = 1'b0;
         radius      = RADIUS_RESET;
         expected_reports.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               error_count++;
               if (error_count <= SHOWN_ERRORS)
                  $display("%0t: result index %0d arrived with nothing expected",
                           $realtime, rsp_object_index);
            end else begin
               oldest = expected_reports.pop_front();
               if (oldest.obj_index !== rsp_object_index || oldest.ovf !== rsp_overflow ||
                   oldest.closes_set !== rsp_last_result) begin
                  error_count++;
                  if (error_count <= SHOWN_ERRORS)
                     $display({"%0t: result mismatch index %0d/%0d overflow %0b/%0b ",
                               "last %0b/%0b (exp/got)"},
                              $realtime, oldest.obj_index, rsp_object_index, oldest.ovf,
                              rsp_overflow, oldest.closes_set, rsp_last_result);
               end
            end
         end
         if (req_valid && req_ready)
            filter_object(req_pos_x, req_pos_y, req_pos_z, req_last_object);
         if (csr_wr_en)
            radius = csr_wr_data;
      end
      pending_count <= expected_reports.size();
   end

endmodule

### test/topmost_object_occluder_filter_top_tb.sv
// Testbench top for the topmost object occluder filter: drives object items and radius
// writes, throttles the result side, and gives the verdict.
// Depends on toof_pkg, topmost_object_occluder_filter_top and toof_occlusion_checker.
`timescale 1ns / 1ps

module topmost_object_occluder_filter_top_tb;
   import toof_pkg::*;

   localparam int IDLE_PCT        = 18;    // chance per cycle that a side idles
   localparam int RSP_HOLD_CYCLES = 300;   // long receiver hold-off, block must back up
   localparam int SETTLE_CYCLES   = 40;    // margin for an item still in flight
   localparam int STALL_LIMIT     = 3000;  // cycles with no handshake before giving up
   localparam int TARGET_OBJECTS  = 380;

   logic                    clock           = 1'b0;
   logic                    reset           = 1'b1;
   logic                    req_valid       = 1'b0;
   logic                    req_ready;
   logic signed [POS_W-1:0] req_pos_x       = '0;
   logic signed [POS_W-1:0] req_pos_y       = '0;
   logic signed [POS_W-1:0] req_pos_z       = '0;
   logic                    req_last_object = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_ready       = 1'b0;
   logic [IDX_W-1:0]        rsp_object_index;
   logic                    rsp_overflow;
   logic                    rsp_last_result;
   logic                    csr_wr_en       = 1'b0;
   logic [RADIUS_W-1:0]     csr_wr_data     = '0;

   // calm turns off random idling on both sides; hold_armed starts the long hold-off
   logic calm       = 1'b0;
   logic hold_armed = 1'b0;

   int mismatch_count;
   int reports_pending;
   int objects_sent = 0;
   int quiet_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   topmost_object_occluder_filter_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .req_last_object  (req_last_object),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_object_index (rsp_object_index),
      .rsp_overflow     (rsp_overflow),
      .rsp_last_result  (rsp_last_result),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   toof_occlusion_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .req_last_object  (req_last_object),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_object_index (rsp_object_index),
      .rsp_overflow     (rsp_overflow),
      .rsp_last_result  (rsp_last_result),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .error_count      (mismatch_count),
      .pending_count    (reports_pending)
   );

   // Result side: random backpressure, or a long hold when the stimulus arms it.
   // The hold is counted here so the sender keeps offering items meanwhile.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_armed) begin
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES - 1) @(posedge clock);
         end else if (!calm && $urandom_range(99) < IDLE_PCT) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: any handshake on either channel resets the count.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Offers one object and returns at the edge that accepts it. Valid is left high so a
   // following call can keep the channel busy back to back; any other wait must drop it.
   task automatic send_object(input logic signed [POS_W-1:0] px,
                              input logic signed [POS_W-1:0] py,
                              input logic signed [POS_W-1:0] pz,
                              input logic                    last_obj);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_pos_x       <= px;
      req_pos_y       <= py;
      req_pos_z       <= pz;
      req_last_object <= last_obj;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      objects_sent++;
   endtask

   // Stop sending, let every expected result drain, then cover items still in flight
   // that produce no result.
   task automatic drain_block();
      req_valid <= 1'b0;
      @(posedge clock);
      while (reports_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Radius writes only happen on an idle block; the limit settles in the next cycle.
   task automatic set_radius(input logic [RADIUS_W-1:0] value);
      drain_block();
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      repeat (4) @(posedge clock);
   endtask

   // One set of objects clustered around a random spot, so that overlaps, ties in height
   // and blocking are common; a few objects land anywhere. Mostly short sets, some long
   // enough to fill the table.
   task automatic send_random_set(input int span);
      logic signed [POS_W-1:0] bx, by, bz, px, py, pz;
      int                      n, ox, oy;
      bx = $urandom;
      by = $urandom;
      bz = $urandom;
      n  = ($urandom_range(99) < 10) ? $urandom_range(20, 45) : $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 8) begin
            px = $urandom;
            py = $urandom;
         end else begin
            ox = int'($urandom_range(0, 2 * span)) - span;
            oy = int'($urandom_range(0, 2 * span)) - span;
            px = bx + ox;
            py = by + oy;
         end
         pz = ($urandom_range(99) < 15) ? $urandom : bz + int'($urandom_range(0, 15));
         send_object(px, py, pz, i == n - 1);
      end
   endtask

   task automatic send_sets_until(input int target, input int span);
      while (objects_sent < target) send_random_set(span);
   endtask

   initial begin
      int r;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed sets at the reset radius of 4000 (overlap below 8000 um).
      // Lone object: the first of a set is always kept.
      send_object(0, 0, 0, 1'b1);
      // Corners of the coordinate space: squared sums past 64 bits count as far apart.
      send_object(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
      send_object(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
      send_object(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 1'b1);
      // Lower newcomer blocked; higher newcomer removes the lower entry; equal height
      // blocks; exactly 2 * radius apart is no overlap.
      send_object(0, 0, 100, 1'b0);
      send_object(1000, 0, 50, 1'b0);
      send_object(2000, 0, 200, 1'b0);
      send_object(7999, 0, 200, 1'b0);
      send_object(20000, 0, 0, 1'b0);
      send_object(27999, 0, 10, 1'b0);
      send_object(35999, 0, -5, 1'b1);
      // Lower entry marked, then a higher one blocks: the mark still removes it.
      send_object(0, 0, 10, 1'b0);
      send_object(10000, 0, 100, 1'b0);
      send_object(5000, 0, 50, 1'b1);
      // Blocker comes first in the list: the lower entry after it survives.
      send_object(0, -3000, 100, 1'b0);
      send_object(10000, -3000, 10, 1'b0);
      send_object(5000, -3000, 50, 1'b1);

      // Same spot, rising height: each object replaces the previous one and the
      // arrival number wraps past 63.
      for (int i = 0; i < 66; i++)
         send_object(123456, -654321, i * 10 - 300, i == 65);

      // Long stretch with no idling on either side.
      calm <= 1'b1;
      send_sets_until(140, 12000);
      calm <= 1'b0;
      send_sets_until(170, 12000);

      // Radius 0: nothing overlaps, so a long set fills the table and overflows.
      set_radius('0);
      for (int i = 0; i < 40; i++)
         send_object($urandom, $urandom, $urandom, i == 39);
      send_sets_until(220, 100);

      set_radius({RADIUS_W{1'b1}});
      send_sets_until(260, 3000000);

      // Sender pause with everything drained, then the long receiver hold-off while
      // the sender keeps going, so results back up and the input stalls.
      drain_block();
      hold_armed <= 1'b1;
      @(posedge clock);
      hold_armed <= 1'b0;
      send_random_set(3000000);
      send_random_set(3000000);
      send_sets_until(285, 3000000);

      set_radius(1);
      send_sets_until(320, 3);

      r = $urandom_range(2, 1048574);
      set_radius(RADIUS_W'(r));
      send_sets_until(350, 3 * r);

      set_radius(20'd4000);
      send_sets_until(TARGET_OBJECTS, 12000);

      drain_block();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
